/* rtl/u2u_pkg.sv */
package u2u_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_LEAD     = 2'd1,
		ST_MISSING_CONT = 2'd2,
		ST_FULL         = 2'd3
	} status_t;

	// decoder phase
	typedef enum logic [1:0] {
		PH_LEAD        = 2'd0,
		PH_LAST_OF_2   = 2'd1,
		PH_SECOND_OF_3 = 2'd2,
		PH_LAST_OF_3   = 2'd3
	} phase_t;

	// configuration register indexes
	localparam logic CFG_DEST_CAPACITY = 1'b0;
	localparam logic CFG_COUNT_ONLY    = 1'b1;

	localparam int UNIT_W = 16;
	localparam logic [UNIT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		phase_t              phase;
		logic [UNIT_W-1:0]   partial;
		logic [UNIT_W-1:0]   units;
		logic                discarding;
	} dec_state_t;

	typedef struct packed {
		logic [UNIT_W-1:0] capacity;
		logic              count_only;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [UNIT_W-1:0] code_unit;
		logic              is_last;
		logic [UNIT_W-1:0] unit_count;
		status_t           status;
	} dec_result_t;

endpackage

/* rtl/u2u_cfg.sv */
module u2u_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [u2u_pkg::UNIT_W-1:0] cfg_data,
	output u2u_pkg::cfg_t             cfg
);

	u2u_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity   <= u2u_pkg::COUNT_MAX;
			cfg_q.count_only <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				u2u_pkg::CFG_DEST_CAPACITY: cfg_q.capacity <= cfg_data;
				u2u_pkg::CFG_COUNT_ONLY:    cfg_q.count_only <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/u2u_step.sv */
module u2u_step (
	input  logic [7:0]          byte_in,
	input  u2u_pkg::cfg_t       cfg,
	input  u2u_pkg::dec_state_t cur,
	output u2u_pkg::dec_state_t nxt,
	output u2u_pkg::dec_result_t res
);

	logic                       is_nul;
	logic                       is_ascii;
	logic                       is_cont;
	logic                       is_lead2;
	logic                       is_lead3;
	logic [u2u_pkg::UNIT_W-1:0] units_inc;
	logic [u2u_pkg::UNIT_W-1:0] cont_unit;

	assign is_nul    = (byte_in == 8'h00);
	assign is_ascii  = !byte_in[7];
	assign is_cont   = (byte_in[7:6] == 2'b10);
	assign is_lead2  = (byte_in[7:5] == 3'b110);
	assign is_lead3  = (byte_in[7:4] == 4'b1110);
	assign units_inc = (cur.units == u2u_pkg::COUNT_MAX) ? cur.units
		: cur.units + u2u_pkg::UNIT_W'(1);
	assign cont_unit = cur.partial | {10'd0, byte_in[5:0]};

	always_comb begin
		nxt            = cur;
		res.valid      = 1'b0;
		res.code_unit  = '0;
		res.is_last    = 1'b0;
		res.unit_count = cur.units;
		res.status     = u2u_pkg::ST_OK;

		if (cur.discarding) begin
			// drop bytes through the terminator
			if (is_nul) begin
				nxt = '0;
			end
		end else begin
			if (!cfg.count_only && !(cur.units < cfg.capacity)) begin
				res.valid   = 1'b1;
				res.is_last = 1'b1;
				res.status  = u2u_pkg::ST_FULL;
			end else begin
				case (cur.phase)
					u2u_pkg::PH_LEAD: begin
						if (is_ascii) begin
							nxt.units     = units_inc;
							res.code_unit = {9'd0, byte_in[6:0]};
							res.unit_count = units_inc;
							res.is_last   = is_nul;
							res.valid     = is_nul || !cfg.count_only;
						end else if (is_lead2) begin
							nxt.partial = {5'd0, byte_in[4:0], 6'd0};
							nxt.phase   = u2u_pkg::PH_LAST_OF_2;
						end else if (is_lead3) begin
							nxt.partial = {byte_in[3:0], 12'd0};
							nxt.phase   = u2u_pkg::PH_SECOND_OF_3;
						end else begin
							res.valid   = 1'b1;
							res.is_last = 1'b1;
							res.status  = u2u_pkg::ST_BAD_LEAD;
						end
					end
					u2u_pkg::PH_SECOND_OF_3: begin
						if (is_cont) begin
							nxt.partial = cur.partial | {4'd0, byte_in[5:0], 6'd0};
							nxt.phase   = u2u_pkg::PH_LAST_OF_3;
						end else begin
							res.valid   = 1'b1;
							res.is_last = 1'b1;
							res.status  = u2u_pkg::ST_MISSING_CONT;
						end
					end
					u2u_pkg::PH_LAST_OF_2, u2u_pkg::PH_LAST_OF_3: begin
						if (is_cont) begin
							nxt.units      = units_inc;
							nxt.phase      = u2u_pkg::PH_LEAD;
							res.code_unit  = cont_unit;
							res.unit_count = units_inc;
							res.valid      = !cfg.count_only;
						end else begin
							res.valid   = 1'b1;
							res.is_last = 1'b1;
							res.status  = u2u_pkg::ST_MISSING_CONT;
						end
					end
					default: begin
						nxt = cur;
					end
				endcase
			end

			// end of string: terminator or error
			if (res.is_last) begin
				if (is_nul) begin
					nxt = '0;
				end else begin
					nxt.discarding = 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/utf8_to_ucs2_decoder.sv */
// UTF-8 to UCS-2 decoder. Bytes of a NUL-terminated UTF-8 string enter on
// the in_* channel, one transaction per byte, and 16-bit code units leave on
// the out_* channel. One-, two- and three-byte sequences are decoded with no
// overlong or surrogate checks; the terminating NUL comes out as a unit of
// value 0 with is_last set, and the decoder then starts a new string. An
// error (bad lead byte, missing continuation, or unit count reaching
// dest_capacity, checked before every byte unless count_only is set) gives
// one transaction with is_last set, code_unit 0 and the status code, after
// which bytes are dropped through the next NUL unless that byte was the NUL.
// With count_only set, only the final transaction of each string is given,
// with the unit count saturating at 65535. Throughput is one byte per clock
// unless a result waits under out_stall: a byte is registered, decoded
// against the phase/partial/count state, and its result is registered once
// the output register is free. While a result waits under out_stall and a
// byte sits behind it, in_stall follows out_stall. Configuration writes take
// effect from the next byte and should be made while idle.
module utf8_to_ucs2_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	// code unit output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_unit,
	output logic        is_last,
	output logic [15:0] unit_count,
	output logic [1:0]  status
);

	u2u_pkg::cfg_t       cfg;
	u2u_pkg::dec_state_t state_q;
	u2u_pkg::dec_state_t state_nxt;
	u2u_pkg::dec_result_t res;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;

	logic        out_valid_q;
	logic [15:0] code_unit_q;
	logic        is_last_q;
	logic [15:0] unit_count_q;
	logic [1:0]  status_q;

	u2u_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// output register can take a new result this cycle
	assign out_free = !out_valid_q || !out_stall;
	// the registered byte is decoded and retired
	assign advance  = valid_s1 && out_free;
	// input stage holds only while its byte cannot retire
	assign in_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	// combinational decode step
	u2u_step u_step (
		.byte_in (byte_s1),
		.cfg     (cfg),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	// decoder state, updated once per retired byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			code_unit_q  <= res.code_unit;
			is_last_q    <= res.is_last;
			unit_count_q <= res.unit_count;
			status_q     <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_unit  = code_unit_q;
	assign is_last    = is_last_q;
	assign unit_count = unit_count_q;
	assign status     = status_q;

endmodule
